@@ rtl/bgd_pkg.sv @@
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants for the button gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

   localparam int TickWidth   = 8;
   localparam int WindowWidth = 16;
   localparam int LongWidth   = 16;
   localparam int CsrWidth    = 16;
   localparam int CsrIdxWidth = 2;
   localparam int CountWidth  = 17;
   localparam int MsWidth     = CountWidth + TickWidth;

   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
   // reset window value of 300 plus one, held as a tick count
   localparam logic [CountWidth-1:0] ReleaseReset = CountWidth'(301);

   localparam logic [TickWidth-1:0]   TickReset   = TickWidth'(10);
   localparam logic [WindowWidth-1:0] WindowReset = WindowWidth'(300);
   localparam logic [LongWidth-1:0]   LongReset   = LongWidth'(1000);

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TICK_PERIOD = 2'd0,
      CSR_DC_WINDOW   = 2'd1,
      CSR_LONG_PRESS  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_UP      = 3'd0,
      ST_CONFIRM = 3'd1,
      ST_DOWN    = 3'd2,
      ST_DOUBLE  = 3'd3,
      ST_LONG    = 3'd4
   } state_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_PRESS   = 3'd1,
      EV_CLICK   = 3'd2,
      EV_RELEASE = 3'd3,
      EV_DOUBLE  = 3'd4,
      EV_LONG    = 3'd5,
      EV_SINGLE  = 3'd6
   } event_type;

   typedef struct packed {
      logic [TickWidth-1:0]   tick_period_ms;
      logic [WindowWidth-1:0] double_click_window_ms;
      logic [LongWidth-1:0]   long_press_ms;
   } cfg_type;

   typedef struct packed {
      event_type event_code;
      logic      notify;
   } result_type;

endpackage

@@ rtl/bgd_csr.sv @@
// ----------------------------------------------------------------------------
// bgd_csr
// Configuration registers: tick period, double click window, long press time.
// ----------------------------------------------------------------------------
module bgd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [bgd_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [bgd_pkg::CsrWidth-1:0]       csr_wdata,
   output bgd_pkg::cfg_type                   cfg
);

   bgd_pkg::cfg_type cfg_ff;
   bgd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (bgd_pkg::csr_index_type'(csr_index))
            bgd_pkg::CSR_TICK_PERIOD:
               cfg_in.tick_period_ms = csr_wdata[bgd_pkg::TickWidth-1:0];
            bgd_pkg::CSR_DC_WINDOW:
               cfg_in.double_click_window_ms = csr_wdata[bgd_pkg::WindowWidth-1:0];
            bgd_pkg::CSR_LONG_PRESS:
               cfg_in.long_press_ms = csr_wdata[bgd_pkg::LongWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_period_ms         <= bgd_pkg::TickReset;
         cfg_ff.double_click_window_ms <= bgd_pkg::WindowReset;
         cfg_ff.long_press_ms          <= bgd_pkg::LongReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/bgd_core.sv @@
// ----------------------------------------------------------------------------
// bgd_core
// Gesture state machine with press and release tick counters; one tick is
// applied per cycle in which step is high.
// ----------------------------------------------------------------------------
module bgd_core (
   input  logic                  clock,
   input  logic                  reset,
   input  bgd_pkg::cfg_type      cfg,
   input  logic                  step,
   input  logic                  level,
   output bgd_pkg::result_type   result
);

   bgd_pkg::state_type               state_ff, state_in;
   bgd_pkg::event_type               event_ff, event_in;
   logic [bgd_pkg::CountWidth-1:0]   release_ff, release_in;
   logic [bgd_pkg::CountWidth-1:0]   hold_ff, hold_in;
   logic                             notify;

   logic [bgd_pkg::CountWidth-1:0]   release_inc;
   logic [bgd_pkg::CountWidth-1:0]   hold_inc;
   logic [bgd_pkg::MsWidth-1:0]      release_ms;
   logic [bgd_pkg::MsWidth-1:0]      hold_ms;
   logic [bgd_pkg::MsWidth-1:0]      window_ms;
   logic                             in_window;
   logic                             at_window;
   logic                             long_hit;

   assign release_inc = (release_ff == bgd_pkg::CountMax) ? release_ff
                                                          : release_ff + 1'b1;
   assign hold_inc    = (hold_ff == bgd_pkg::CountMax) ? hold_ff : hold_ff + 1'b1;

   assign release_ms = bgd_pkg::MsWidth'(release_ff) * bgd_pkg::MsWidth'(cfg.tick_period_ms);
   // the down state counts the current tick before comparing
   assign hold_ms    = bgd_pkg::MsWidth'(hold_inc) * bgd_pkg::MsWidth'(cfg.tick_period_ms);
   assign window_ms  = bgd_pkg::MsWidth'(cfg.double_click_window_ms);
   assign in_window  = release_ms < window_ms;
   assign at_window  = release_ms == window_ms;
   assign long_hit   = hold_ms > bgd_pkg::MsWidth'(cfg.long_press_ms);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bgd_pkg::ST_UP:      if (level) state_in = bgd_pkg::ST_CONFIRM;
         bgd_pkg::ST_CONFIRM: begin
            if (!level)         state_in = bgd_pkg::ST_UP;
            else if (in_window) state_in = bgd_pkg::ST_DOUBLE;
            else                state_in = bgd_pkg::ST_DOWN;
         end
         bgd_pkg::ST_DOWN: begin
            if (!level)        state_in = bgd_pkg::ST_UP;
            else if (long_hit) state_in = bgd_pkg::ST_LONG;
         end
         bgd_pkg::ST_DOUBLE:  if (!level) state_in = bgd_pkg::ST_UP;
         bgd_pkg::ST_LONG:    if (!level) state_in = bgd_pkg::ST_UP;
         default:             state_in = bgd_pkg::ST_UP;
      endcase
   end

   // event, notification and counters
   always_comb begin
      event_in   = event_ff;
      notify     = 1'b0;
      release_in = release_ff;
      hold_in    = hold_ff;
      unique case (state_ff)
         bgd_pkg::ST_UP: begin
            if (level) begin
               event_in = bgd_pkg::EV_NONE;
            end else begin
               if (event_ff == bgd_pkg::EV_CLICK) begin
                  event_in = bgd_pkg::EV_RELEASE;
                  notify   = 1'b1;
               end else begin
                  event_in = bgd_pkg::EV_NONE;
               end
               if (in_window) begin
                  release_in = release_inc;
               end else if (at_window) begin
                  release_in = release_inc;
                  event_in   = bgd_pkg::EV_SINGLE;
                  notify     = 1'b1;
               end
            end
         end
         bgd_pkg::ST_CONFIRM: begin
            if (level) begin
               notify = 1'b1;
               if (in_window) begin
                  event_in = bgd_pkg::EV_DOUBLE;
               end else begin
                  release_in = '0;
                  event_in   = bgd_pkg::EV_PRESS;
               end
            end else begin
               event_in = bgd_pkg::EV_NONE;
            end
         end
         bgd_pkg::ST_DOWN: begin
            hold_in = hold_inc;
            if (level) begin
               if (long_hit) begin
                  hold_in  = '0;
                  event_in = bgd_pkg::EV_LONG;
                  notify   = 1'b1;
               end else begin
                  event_in = bgd_pkg::EV_NONE;
               end
            end else begin
               hold_in  = '0;
               event_in = bgd_pkg::EV_CLICK;
               notify   = 1'b1;
            end
         end
         bgd_pkg::ST_DOUBLE: begin
            if (level) begin
               event_in = bgd_pkg::EV_NONE;
            end else begin
               release_in = bgd_pkg::CountWidth'(cfg.double_click_window_ms) + 1'b1;
               event_in   = bgd_pkg::EV_RELEASE;
               notify     = 1'b1;
            end
         end
         bgd_pkg::ST_LONG: begin
            if (level) begin
               event_in = bgd_pkg::EV_NONE;
            end else begin
               event_in = bgd_pkg::EV_RELEASE;
               notify   = 1'b1;
            end
         end
         default: event_in = bgd_pkg::EV_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bgd_pkg::ST_UP;
         event_ff   <= bgd_pkg::EV_NONE;
         release_ff <= bgd_pkg::ReleaseReset;
         hold_ff    <= '0;
      end else if (step) begin
         state_ff   <= state_in;
         event_ff   <= event_in;
         release_ff <= release_in;
         hold_ff    <= hold_in;
      end
   end

   assign result.event_code = event_in;
   assign result.notify     = notify;

endmodule

@@ rtl/button_gesture_detector.sv @@
// ----------------------------------------------------------------------------
// button_gesture_detector
// Turns sampled button ticks into press, click, release, double click, long
// press and single click events.
//
//   channel  ports                         direction  content
//   req      req_valid/req_stall/req_level in         one tick, button level
//   rsp      rsp_valid/rsp_stall/rsp_*     out        stored event and notify
//   csr      csr_write/csr_index/csr_wdata in         register write
//
// One tick is taken per clock while req_stall is low; an accepted tick passes
// through the input register, then the result register, which offers its result.
// The state update is a single pass through the gesture logic per tick.
// Reset is synchronous and clears state, counters, configuration and valid flags to defaults.
// A stalled result holds its register; one more tick waits in the input
// register, after which req_stall rises.
// ----------------------------------------------------------------------------
module button_gesture_detector (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_level,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_event_code,
   output logic                            rsp_notify,
   input  logic                            csr_write,
   input  logic [bgd_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [bgd_pkg::CsrWidth-1:0]    csr_wdata
);

   bgd_pkg::cfg_type    cfg;
   bgd_pkg::result_type result;

   logic                in_valid_ff, in_valid_in;
   logic                in_level_ff, in_level_in;
   logic                out_valid_ff, out_valid_in;
   bgd_pkg::result_type out_ff, out_in;
   logic                req_take;
   logic                advance;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_level_in  = in_level_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_level_in = req_level;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_level_ff <= in_level_in;
      out_ff      <= out_in;
   end

   bgd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bgd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .level  (in_level_ff),
      .result (result)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_code = out_ff.event_code;
   assign rsp_notify     = out_ff.notify;

endmodule

@@ verif/button_gesture_detector_tb.sv @@
// ----------------------------------------------------------------------------
// button_gesture_detector_tb
// Self-checking testbench for the button gesture detector. A queue of button
// ticks feeds a valid/stall driver. Each accepted tick is run through a
// gesture predictor kept in the testbench. The monitor checks every result
// transaction against the oldest predicted event. Register settings change
// between phases, only once the block has drained.
// ----------------------------------------------------------------------------
module button_gesture_detector_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 400_000;
   localparam int ZeroTickRun = 30;
   localparam int HoldOffAt = 500;
   localparam int HoldOffCycles = 80;
   localparam int PrintLimit = 50;
   localparam int PhaseItems = 120;
   localparam logic [bgd_pkg::CsrIdxWidth-1:0] CsrSpare = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_level = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_event_code;
   logic rsp_notify;
   logic csr_write = 1'b0;
   logic [bgd_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [bgd_pkg::CsrWidth-1:0] csr_wdata = '0;

   // gesture predictor state
   bgd_pkg::cfg_type cfg = '{bgd_pkg::TickReset, bgd_pkg::WindowReset, bgd_pkg::LongReset};
   bgd_pkg::state_type gest_state = bgd_pkg::ST_UP;
   bgd_pkg::event_type gest_event = bgd_pkg::EV_NONE;
   logic [bgd_pkg::CountWidth-1:0] release_count = bgd_pkg::ReleaseReset;
   logic [bgd_pkg::CountWidth-1:0] hold_count = '0;

   logic level_queue[$];
   bgd_pkg::result_type event_due[$];
   bgd_pkg::result_type want;

   logic steady = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int hold_off_left = 0;
   logic held_off = 1'b0;
   int results_seen = 0;
   int mismatches = 0;
   int cycle_count = 0;

   button_gesture_detector uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_level      (req_level),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_code (rsp_event_code),
      .rsp_notify     (rsp_notify),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic logic [bgd_pkg::MsWidth-1:0] to_ms(
         input logic [bgd_pkg::CountWidth-1:0] ticks);
      return bgd_pkg::MsWidth'(ticks) * bgd_pkg::MsWidth'(cfg.tick_period_ms);
   endfunction

   function automatic logic [bgd_pkg::CountWidth-1:0] bump(
         input logic [bgd_pkg::CountWidth-1:0] v);
      return (v == bgd_pkg::CountMax) ? v : v + 1'b1;
   endfunction

   function automatic bgd_pkg::result_type next_gesture(input logic pressed);
      bgd_pkg::result_type res;
      logic raised;
      logic [bgd_pkg::MsWidth-1:0] win;
      raised = 1'b0;
      win = bgd_pkg::MsWidth'(cfg.double_click_window_ms);
      case (gest_state)
         bgd_pkg::ST_UP: begin
            if (pressed) begin
               gest_state = bgd_pkg::ST_CONFIRM;
               gest_event = bgd_pkg::EV_NONE;
            end else begin
               if (gest_event == bgd_pkg::EV_CLICK) begin
                  gest_event = bgd_pkg::EV_RELEASE;
                  raised = 1'b1;
               end else begin
                  gest_event = bgd_pkg::EV_NONE;
               end
               if (to_ms(release_count) < win) begin
                  release_count = bump(release_count);
               end else if (to_ms(release_count) == win) begin
                  release_count = bump(release_count);
                  gest_event = bgd_pkg::EV_SINGLE;
                  raised = 1'b1;
               end
            end
         end
         bgd_pkg::ST_CONFIRM: begin
            if (pressed) begin
               if (to_ms(release_count) < win) begin
                  gest_state = bgd_pkg::ST_DOUBLE;
                  gest_event = bgd_pkg::EV_DOUBLE;
               end else begin
                  release_count = '0;
                  gest_state = bgd_pkg::ST_DOWN;
                  gest_event = bgd_pkg::EV_PRESS;
               end
               raised = 1'b1;
            end else begin
               gest_state = bgd_pkg::ST_UP;
               gest_event = bgd_pkg::EV_NONE;
            end
         end
         bgd_pkg::ST_DOUBLE: begin
            if (pressed) begin
               gest_event = bgd_pkg::EV_NONE;
            end else begin
               // reload uses the window register as it stands now
               release_count = bgd_pkg::CountWidth'(cfg.double_click_window_ms) + 1'b1;
               gest_state = bgd_pkg::ST_UP;
               gest_event = bgd_pkg::EV_RELEASE;
               raised = 1'b1;
            end
         end
         bgd_pkg::ST_DOWN: begin
            hold_count = bump(hold_count);
            if (pressed) begin
               if (to_ms(hold_count) > bgd_pkg::MsWidth'(cfg.long_press_ms)) begin
                  hold_count = '0;
                  gest_state = bgd_pkg::ST_LONG;
                  gest_event = bgd_pkg::EV_LONG;
                  raised = 1'b1;
               end else begin
                  gest_event = bgd_pkg::EV_NONE;
               end
            end else begin
               hold_count = '0;
               gest_state = bgd_pkg::ST_UP;
               gest_event = bgd_pkg::EV_CLICK;
               raised = 1'b1;
            end
         end
         bgd_pkg::ST_LONG: begin
            if (pressed) begin
               gest_event = bgd_pkg::EV_NONE;
            end else begin
               gest_state = bgd_pkg::ST_UP;
               gest_event = bgd_pkg::EV_RELEASE;
               raised = 1'b1;
            end
         end
         default: begin
            gest_state = bgd_pkg::ST_UP;
            gest_event = bgd_pkg::EV_NONE;
         end
      endcase
      res.event_code = gest_event;
      res.notify = raised;
      return res;
   endfunction

   // mostly no gap, some short ones, a few long ones
   function automatic int pick_gap(input int start_pct);
      if (steady || $urandom_range(0, 99) >= start_pct) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // run length close to a threshold, or anywhere up to twice it plus two
   function automatic int near(input int t);
      case ($urandom_range(0, 3))
         0: return (t > 1) ? t - 1 : 1;
         1: return t;
         2: return t + 1;
         default: return $urandom_range(1, 2 * t + 2);
      endcase
   endfunction

   // tick driver
   always @(posedge clock) begin
      logic sending;
      if (reset) begin
         req_valid <= 1'b0;
         req_level <= 1'b0;
         gap_left = 0;
      end else begin
         sending = req_valid;
         if (req_valid && !req_stall) begin
            event_due.push_back(next_gesture(req_level));
            sending = 1'b0;
         end
         if (!sending) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (level_queue.size() > 0) begin
               req_level <= level_queue.pop_front();
               sending = 1'b1;
               gap_left = pick_gap(45);
            end
         end
         req_valid <= sending;
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (event_due.size() == 0) begin
               if (mismatches < PrintLimit)
                  $display("%0t: unexpected result transaction event_code %0d notify %0d",
                           $time, rsp_event_code, rsp_notify);
               mismatches++;
            end else begin
               want = event_due.pop_front();
               if (rsp_event_code !== want.event_code) begin
                  if (mismatches < PrintLimit)
                     $display("%0t: event_code expected %0d actual %0d",
                              $time, want.event_code, rsp_event_code);
                  mismatches++;
               end
               if (rsp_notify !== want.notify) begin
                  if (mismatches < PrintLimit)
                     $display("%0t: notify expected %0d actual %0d",
                              $time, want.notify, rsp_notify);
                  mismatches++;
               end
            end
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_stall <= 1'b1;
         end else if (!held_off && results_seen >= HoldOffAt) begin
            // one long hold-off so the block backs up and stalls its input
            held_off = 1'b1;
            hold_off_left = HoldOffCycles - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 1) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = pick_gap(25);
            rsp_stall <= (stall_left != 0);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_reg(input logic [bgd_pkg::CsrIdxWidth-1:0] idx,
                            input logic [bgd_pkg::CsrWidth-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         bgd_pkg::CSR_TICK_PERIOD:
            cfg.tick_period_ms = data[bgd_pkg::TickWidth-1:0];
         bgd_pkg::CSR_DC_WINDOW:
            cfg.double_click_window_ms = data[bgd_pkg::WindowWidth-1:0];
         bgd_pkg::CSR_LONG_PRESS:
            cfg.long_press_ms = data[bgd_pkg::LongWidth-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (level_queue.size() != 0 || req_valid || event_due.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic push_levels(input string s);
      for (int i = 0; i < s.len(); i++) level_queue.push_back(s[i] == "1");
   endtask

   // presses and releases sized around the current thresholds, with occasional random bounce runs
   task automatic queue_gestures(input int n_items);
      int added;
      int hold_n;
      int gap_n;
      int tick;
      int win_t;
      int long_t;
      tick = (cfg.tick_period_ms == 0) ? 1 : int'(cfg.tick_period_ms);
      win_t = int'(cfg.double_click_window_ms) / tick + 2;
      long_t = int'(cfg.long_press_ms) / tick + 3;
      added = 0;
      while (added < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            gap_n = $urandom_range(1, 6);
            repeat (gap_n) level_queue.push_back(1'($urandom_range(0, 1)));
            added += gap_n;
         end else begin
            hold_n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : near(long_t);
            gap_n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : near(win_t);
            repeat (hold_n) level_queue.push_back(1'b1);
            repeat (gap_n) level_queue.push_back(1'b0);
            added += hold_n + gap_n;
         end
      end
   endtask

   task automatic run_phase(input int tick, input int win, input int hold, input int n_items,
                            input logic calm);
      write_reg(bgd_pkg::CSR_TICK_PERIOD, bgd_pkg::CsrWidth'(tick));
      write_reg(bgd_pkg::CSR_DC_WINDOW, bgd_pkg::CsrWidth'(win));
      write_reg(bgd_pkg::CSR_LONG_PRESS, bgd_pkg::CsrWidth'(hold));
      steady = calm;
      queue_gestures(n_items);
      wait_idle();
      steady = 1'b0;
   endtask

   initial begin
      int tick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // click, release, double click, long press, single click, bounce
      write_reg(bgd_pkg::CSR_DC_WINDOW, 16'd30);
      write_reg(bgd_pkg::CSR_LONG_PRESS, 16'd20);
      push_levels("0111001110011111100000010");
      wait_idle();

      // zero window: release and single land on the same tick
      write_reg(bgd_pkg::CSR_DC_WINDOW, 16'd0);
      push_levels("11000");
      wait_idle();

      // zero tick period, upper data bits masked off: long press never fires
      write_reg(bgd_pkg::CSR_TICK_PERIOD, 16'hFF00);
      steady = 1'b1;
      repeat (ZeroTickRun) level_queue.push_back(1'b0);
      repeat (ZeroTickRun + 2) level_queue.push_back(1'b1);
      push_levels("00");
      wait_idle();
      steady = 1'b0;

      // spare register index is ignored
      write_reg(CsrSpare, bgd_pkg::CsrWidth'($urandom_range(0, 65535)));
      run_phase(bgd_pkg::TickReset, bgd_pkg::WindowReset, bgd_pkg::LongReset,
                PhaseItems, 1'b0);
      run_phase(1, 1, 0, PhaseItems, 1'b0);
      run_phase(255, 65535, 65535, PhaseItems, 1'b0);
      for (int p = 0; p < 3; p++) begin
         tick = $urandom_range(1, 255);
         run_phase(tick,
                   (tick * $urandom_range(0, 10) + $urandom_range(0, tick)) % 65536,
                   (tick * $urandom_range(0, 15) + $urandom_range(0, tick)) % 65536,
                   PhaseItems, p == 1);
      end

      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
